### hw/rtl/hcpp_pkg.sv
// shared types, constants and helper functions of the hex command packet parser
package hcpp_pkg;

    // default text length limit in decoded characters
    localparam int MAX_TEXT_DEF = 64;

    localparam int PREFIX_LEN = 6;
    localparam int KW_COUNT   = 6;
    localparam int KW_SLOTS   = 8;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7e;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_UNKNOWN   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_HELP    = 3'd1,
        CMD_STATUS  = 3'd2,
        CMD_THREADS = 3'd3,
        CMD_MODULES = 3'd4,
        CMD_CONSOLE = 3'd5,
        CMD_DISPLAY = 3'd6
    } t_cmd;

    // one parse result
    typedef struct packed {
        t_cmd    cmd;
        t_status status;
    } t_result;

    // keyword spellings, padded with zeros
    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_SLOTS] = '{
        '{"h", "e", "l", "p", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"s", "t", "a", "t", "u", "s", 8'h00, 8'h00},
        '{"t", "h", "r", "e", "a", "d", "s", 8'h00},
        '{"m", "o", "d", "u", "l", "e", "s", 8'h00},
        '{"c", "o", "n", "s", "o", "l", "e", 8'h00},
        '{"d", "i", "s", "p", "l", "a", "y", 8'h00}
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd4, 4'd6, 4'd7, 4'd7, 4'd7, 4'd7
    };

    localparam t_cmd KW_CMD [KW_COUNT] = '{
        CMD_HELP, CMD_STATUS, CMD_THREADS, CMD_MODULES, CMD_CONSOLE, CMD_DISPLAY
    };

    // expected prefix byte at a given position
    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = "q";
            3'd1:    ch = "R";
            3'd2:    ch = "c";
            3'd3:    ch = "m";
            3'd4:    ch = "d";
            3'd5:    ch = ",";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // hex digit decode: bit 4 flags a valid digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
        logic [4:0] res;
        res = 5'd0;
        if (ch >= "0" && ch <= "9") begin
            res = {1'b1, 4'(ch - 8'h30)};
        end else if (ch >= "a" && ch <= "f") begin
            res = {1'b1, 4'(ch - 8'h57)};
        end else if (ch >= "A" && ch <= "F") begin
            res = {1'b1, 4'(ch - 8'h37)};
        end
        return res;
    endfunction

endpackage

### hw/rtl/hcpp_parse.sv
// per-byte parse state and the end-of-packet verdict
module hcpp_parse #(
    parameter int MAX_TEXT = hcpp_pkg::MAX_TEXT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output logic              o_load,
    output hcpp_pkg::t_result o_result
);
    import hcpp_pkg::*;

    // length counter saturates one past the limit
    localparam int         TLW   = $clog2(MAX_TEXT + 2);
    localparam logic [TLW-1:0] MAX_L = TLW'(MAX_TEXT);
    localparam logic [2:0] PFX_END = 3'(PREFIX_LEN);

    logic [2:0]     r_prefix_pos,  n_prefix_pos;
    logic [TLW-1:0] r_text_len,    n_text_len;
    logic           r_nib_due,     n_nib_due;
    logic [3:0]     r_high_nib,    n_high_nib;
    logic           r_malformed,   n_malformed;
    logic [KW_COUNT-1:0] r_alive,  n_alive;
    logic [3:0]     r_kw_pos,      n_kw_pos;
    logic           r_content,     n_content;
    logic           r_blank_after, n_blank_after;

    logic [4:0]     nib;
    logic [7:0]     ch;
    logic [TLW-1:0] len_inc;
    logic [KW_COUNT-1:0] alive_in;
    t_result        res;

    // next parse state for the byte being transferred
    always_comb begin
        n_prefix_pos  = r_prefix_pos;
        n_text_len    = r_text_len;
        n_nib_due     = r_nib_due;
        n_high_nib    = r_high_nib;
        n_malformed   = r_malformed;
        n_alive       = r_alive;
        n_kw_pos      = r_kw_pos;
        n_content     = r_content;
        n_blank_after = r_blank_after;
        nib      = hex_nibble(i_byte);
        ch       = {r_high_nib, nib[3:0]};
        len_inc  = (r_text_len <= MAX_L) ? r_text_len + 1'b1 : r_text_len;
        alive_in = r_blank_after ? '0 : r_alive;

        if (i_accept && !r_malformed) begin
            if (r_prefix_pos < PFX_END) begin
                if (i_byte != prefix_char(r_prefix_pos)) begin
                    n_malformed = 1'b1;
                end else begin
                    n_prefix_pos = r_prefix_pos + 3'd1;
                end
            end else if (!nib[4]) begin
                n_malformed = 1'b1;
            end else if (!r_nib_due) begin
                n_high_nib = nib[3:0];
                n_nib_due  = 1'b1;
            end else begin
                n_nib_due = 1'b0;
                // one decoded character
                if ((ch < CH_SPACE && ch != CH_TAB) || ch > CH_TILDE) begin
                    n_malformed = 1'b1;
                end else begin
                    n_text_len = len_inc;
                    if (len_inc > MAX_L) begin
                        n_malformed = 1'b1;
                    end else if (ch == CH_SPACE || ch == CH_TAB) begin
                        if (r_content) begin
                            n_blank_after = 1'b1;
                        end
                    end else begin
                        n_blank_after = 1'b0;
                        n_content     = 1'b1;
                        for (int k = 0; k < KW_COUNT; k++) begin
                            n_alive[k] = alive_in[k] && (r_kw_pos < KW_LEN[k]) &&
                                         (KW_TEXT[k][r_kw_pos[2:0]] == ch);
                        end
                        if (r_kw_pos != 4'hf) begin
                            n_kw_pos = r_kw_pos + 4'd1;
                        end
                    end
                end
            end
        end

        // verdict from the state after this byte, lowest keyword first
        res.status = ST_UNKNOWN;
        res.cmd    = CMD_NONE;
        if (n_malformed || n_prefix_pos < PFX_END || n_nib_due) begin
            res.status = ST_MALFORMED;
        end else begin
            for (int k = KW_COUNT - 1; k >= 0; k--) begin
                if (n_alive[k] && n_kw_pos == KW_LEN[k]) begin
                    res.status = ST_OK;
                    res.cmd    = KW_CMD[k];
                end
            end
        end

        // back to the idle state after the last byte
        if (i_accept && i_last) begin
            n_prefix_pos  = '0;
            n_text_len    = '0;
            n_nib_due     = 1'b0;
            n_high_nib    = '0;
            n_malformed   = 1'b0;
            n_alive       = '1;
            n_kw_pos      = '0;
            n_content     = 1'b0;
            n_blank_after = 1'b0;
        end
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_pos  <= '0;
            r_text_len    <= '0;
            r_nib_due     <= 1'b0;
            r_high_nib    <= '0;
            r_malformed   <= 1'b0;
            r_alive       <= '1;
            r_kw_pos      <= '0;
            r_content     <= 1'b0;
            r_blank_after <= 1'b0;
        end else begin
            r_prefix_pos  <= n_prefix_pos;
            r_text_len    <= n_text_len;
            r_nib_due     <= n_nib_due;
            r_high_nib    <= n_high_nib;
            r_malformed   <= n_malformed;
            r_alive       <= n_alive;
            r_kw_pos      <= n_kw_pos;
            r_content     <= n_content;
            r_blank_after <= n_blank_after;
        end
    end

    assign o_load   = i_accept && i_last;
    assign o_result = res;

endmodule

### hw/rtl/hcpp_out_reg.sv
// result register on the master side
module hcpp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  hcpp_pkg::t_result i_result,
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    output hcpp_pkg::t_result o_result,
    output logic              o_free
);
    import hcpp_pkg::*;

    logic    r_valid;
    t_result r_result;

    // slot is free when empty or drained this cycle
    assign o_free = !r_valid || i_m_tready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_result   = r_result;

endmodule

### hw/rtl/hex_command_packet_parser.sv
// top level of the hex command packet parser
//
//   channel   | dir | handshake             | payload
//   ----------+-----+-----------------------+--------------------------------------
//   slave     | in  | i_s_tvalid/o_s_tready | tdata: packet_byte[7:0]; tlast: is_last
//   master    | out | o_m_tvalid/i_m_tready | tdata: parse_status[1:0], command_code[4:2]
//
// one packet byte per cycle while the slave side is not stalled; the verdict is formed
// combinationally from the byte and the parse state and is loaded at the edge that
// transfers the last byte, so it is offered on the master side in the next cycle.
// synchronous active-low reset returns the parser to the start of a packet
// and empties the result register.
// while a verdict waits with i_m_tready low, the slave side stalls on every byte.
module hex_command_packet_parser #(
    parameter int MAX_TEXT = hcpp_pkg::MAX_TEXT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,  // [7:0] packet_byte
    input  logic       i_s_tlast,  // is_last
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata   // [1:0] parse_status, [4:2] command_code, [7:5] zero
);
    import hcpp_pkg::*;

    logic    free;
    logic    accept;
    logic    load;
    t_result next_res;
    t_result out_res;

    assign o_s_tready = free;
    assign accept     = i_s_tvalid && free;

    // byte parser
    hcpp_parse #(
        .MAX_TEXT(MAX_TEXT)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .o_load   (load),
        .o_result (next_res)
    );

    // result register
    hcpp_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_result   (next_res),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_result   (out_res),
        .o_free     (free)
    );

    assign o_m_tdata = {3'b000, out_res.cmd, out_res.status};

endmodule

### hw/rtl/hcpp_checker.sv
// port-level checks of the hex command packet parser, bound to the top level
module hcpp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic       i_s_tlast,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata
);
    import hcpp_pkg::*;

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // every last-byte transfer produces a result next cycle
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tlast |=> o_m_tvalid)
        else $error("no result after last byte");

    // a new result appears only after a last-byte transfer
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready && i_s_tlast))
        else $error("result without last byte");

    // failed parses carry no command and the status code is legal
    a_status_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[1:0] == ST_OK ||
                        (o_m_tdata[1:0] == ST_MALFORMED && o_m_tdata[4:2] == CMD_NONE) ||
                        (o_m_tdata[1:0] == ST_UNKNOWN && o_m_tdata[4:2] == CMD_NONE)))
        else $error("bad status or command");

endmodule

bind hex_command_packet_parser hcpp_checker u_hcpp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

### dv/hex_command_packet_parser_test.sv
// self-checking testbench of the hex command packet parser with a verdict scoreboard
module hex_command_packet_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hcpp_pkg::*;

    localparam int TEXT_LIMIT  = MAX_TEXT_DEF;
    localparam int IDLE_PCT    = 28;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 900;
    localparam int RAND_PKTS   = 12;

    // expected verdicts and the parse state they are computed from
    class verdict_board;
        t_result expected_verdicts[$];
        int unsigned mismatches;
        string prefix_word = "qRcmd,";

        int unsigned prefix_pos;
        int unsigned text_len;
        int unsigned kw_pos;
        bit nibble_due;
        bit bad_seen;
        bit content_seen;
        bit trailing_blank;
        logic [3:0] high_nibble;
        logic [KW_COUNT-1:0] kw_alive;

        function new();
            mismatches = 0;
            restart();
        endfunction

        // back to the start of a packet
        function void restart();
            prefix_pos     = 0;
            text_len       = 0;
            kw_pos         = 0;
            nibble_due     = 1'b0;
            bad_seen       = 1'b0;
            content_seen   = 1'b0;
            trailing_blank = 1'b0;
            high_nibble    = 4'd0;
            kw_alive       = '1;
        endfunction

        // value of a hex digit of either case, -1 when not a digit
        function int digit_value(logic [7:0] ch);
            if (ch >= "0" && ch <= "9") return int'(ch) - int'("0");
            if (ch >= "a" && ch <= "f") return int'(ch) - int'("a") + 10;
            if (ch >= "A" && ch <= "F") return int'(ch) - int'("A") + 10;
            return -1;
        endfunction

        // one decoded text character
        function void absorb_char(logic [7:0] c);
            int k;
            if ((c < CH_SPACE && c != CH_TAB) || c > CH_TILDE) begin
                bad_seen = 1'b1;
                return;
            end
            // length saturates one past the limit
            if (text_len <= TEXT_LIMIT) text_len++;
            if (text_len > TEXT_LIMIT) begin
                bad_seen = 1'b1;
                return;
            end
            if (c == CH_SPACE || c == CH_TAB) begin
                if (content_seen) trailing_blank = 1'b1;
                return;
            end
            // a blank between content characters kills every keyword
            if (trailing_blank) begin
                kw_alive       = '0;
                trailing_blank = 1'b0;
            end
            content_seen = 1'b1;
            for (k = 0; k < KW_COUNT; k++) begin
                if (kw_alive[k] && (kw_pos >= KW_LEN[k] || KW_TEXT[k][kw_pos & 7] != c)) begin
                    kw_alive[k] = 1'b0;
                end
            end
            if (kw_pos < 15) kw_pos++;
        endfunction

        // accepted input transfer
        function void note_byte(logic [7:0] b, logic last);
            int v;
            int k;
            t_result res;
            if (!bad_seen) begin
                if (prefix_pos < PREFIX_LEN) begin
                    if (b != prefix_word[prefix_pos]) bad_seen = 1'b1;
                    else prefix_pos++;
                end else begin
                    v = digit_value(b);
                    if (v < 0) begin
                        bad_seen = 1'b1;
                    end else if (!nibble_due) begin
                        high_nibble = 4'(v);
                        nibble_due  = 1'b1;
                    end else begin
                        nibble_due = 1'b0;
                        absorb_char({high_nibble, 4'(v)});
                    end
                end
            end
            if (!last) return;
            res.status = ST_UNKNOWN;
            res.cmd    = CMD_NONE;
            if (bad_seen || prefix_pos < PREFIX_LEN || nibble_due) begin
                res.status = ST_MALFORMED;
            end else begin
                for (k = 0; k < KW_COUNT && res.status != ST_OK; k++) begin
                    if (kw_alive[k] && kw_pos == KW_LEN[k]) begin
                        res.status = ST_OK;
                        res.cmd    = KW_CMD[k];
                    end
                end
            end
            expected_verdicts.push_back(res);
            restart();
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%s", msg);
        endfunction

        // accepted output transfer against the oldest expectation
        function void check_verdict(logic [7:0] tdata);
            t_result exp_res;
            t_status got_status;
            t_cmd got_cmd;
            got_status = t_status'(tdata[1:0]);
            got_cmd    = t_cmd'(tdata[4:2]);
            if (expected_verdicts.size() == 0) begin
                flag($sformatf("unexpected verdict status=%0d cmd=%0d", got_status, got_cmd));
                return;
            end
            exp_res = expected_verdicts.pop_front();
            if (got_status != exp_res.status) begin
                flag($sformatf("status mismatch: expected %0d, actual %0d",
                               exp_res.status, got_status));
            end
            if (got_cmd != exp_res.cmd) begin
                flag($sformatf("command mismatch: expected %0d, actual %0d",
                               exp_res.cmd, got_cmd));
            end
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'd0;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;

    verdict_board board = new();
    logic [7:0] pkt[$];
    int hex_case = 0;     // 0 random, 1 lower, 2 upper
    bit calm = 1'b0;      // no idling on either side
    int hold_left = 0;    // receiver hold-off cycles still to go
    int cycle_count = 0;
    int bytes_sent = 0;   // accepted input transfers so far

    hex_command_packet_parser #(
        .MAX_TEXT(TEXT_LIMIT)
    ) i_dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),   // [7:0] packet_byte
        .i_s_tlast (s_tlast),   // is_last
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata)    // [1:0] parse_status, [4:2] command_code
    );

    // clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // cycle limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // receiver with random stalls and a single long hold-off
    initial begin
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // output monitor
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) board.check_verdict(m_tdata);
    end

    // packet building helpers
    function automatic logic [7:0] hex_digit(logic [3:0] n);
        bit upper;
        upper = (hex_case == 0) ? 1'($urandom_range(1)) : (hex_case == 2);
        if (n < 10) return "0" + {4'd0, n};
        return (upper ? "A" : "a") + {4'd0, n} - 8'd10;
    endfunction

    function automatic void put_char(logic [7:0] c);
        pkt.push_back(hex_digit(c[7:4]));
        pkt.push_back(hex_digit(c[3:0]));
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++) put_char(s[i]);
    endfunction

    function automatic void put_raw_str(string s);
        for (int i = 0; i < s.len(); i++) pkt.push_back(s[i]);
    endfunction

    function automatic void put_prefix();
        put_raw_str(board.prefix_word);
    endfunction

    function automatic void put_blanks(int n);
        for (int i = 0; i < n; i++) put_char($urandom_range(1) ? CH_SPACE : CH_TAB);
    endfunction

    function automatic void put_keyword(int k);
        for (int i = 0; i < KW_LEN[k]; i++) put_char(KW_TEXT[k][i]);
    endfunction

    function automatic void put_letters(int n);
        for (int i = 0; i < n; i++) put_char(8'($urandom_range(8'h61, 8'h7a)));
    endfunction

    // one input transfer, with random idle cycles ahead of it
    task automatic send_byte(logic [7:0] b, logic last);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        board.note_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_pkt();
        if (pkt.size() == 0) pkt.push_back(8'($urandom_range(255)));
        for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
        pkt.delete();
    endtask

    // sender pause until every verdict is out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // random packet, mostly well-formed
    task automatic random_packet();
        int kind;
        int sub;
        int k;
        int n;
        int pos;
        kind = $urandom_range(99);
        if (kind < 60) begin
            put_prefix();
            if ($urandom_range(2) == 0) put_blanks($urandom_range(1, 3));
            k   = $urandom_range(KW_COUNT - 1);
            sub = $urandom_range(99);
            pos = $urandom_range(KW_LEN[k] - 1);
            for (int i = 0; i < KW_LEN[k]; i++) begin
                if (sub >= 70 && sub < 80 && i == pos) begin
                    put_char(8'($urandom_range(8'h61, 8'h7a)));
                end else if (sub >= 80 && sub < 88 && i == KW_LEN[k] - 1) begin
                    // truncated keyword
                end else begin
                    if (sub >= 94 && i == pos && i > 0) put_blanks(1);
                    put_char(KW_TEXT[k][i]);
                end
            end
            if (sub >= 88 && sub < 94) put_letters(1);
            if ($urandom_range(2) == 0) put_blanks($urandom_range(1, 3));
        end else if (kind < 72) begin
            put_prefix();
            n = $urandom_range(10);
            for (int i = 0; i < n; i++) begin
                sub = $urandom_range(99);
                if (sub < 10) put_char(8'($urandom_range(255)));
                else if (sub < 20) put_char(CH_TAB);
                else put_char(8'($urandom_range(CH_SPACE, CH_TILDE)));
            end
        end else if (kind < 84) begin
            // well-formed packet broken afterwards
            put_prefix();
            put_keyword($urandom_range(KW_COUNT - 1));
            sub = $urandom_range(2);
            if (sub == 0) begin
                pos = $urandom_range(pkt.size() - 1);
                pkt[pos] = 8'($urandom_range(255));
            end else if (sub == 1) begin
                void'(pkt.pop_back());
            end else begin
                n = $urandom_range(1, pkt.size());
                while (pkt.size() > n) void'(pkt.pop_back());
            end
        end else if (kind < 94) begin
            if ($urandom_range(1)) put_prefix();
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) pkt.push_back(8'($urandom_range(255)));
        end else begin
            // around the text length limit
            put_prefix();
            put_keyword(0);
            put_blanks($urandom_range(TEXT_LIMIT - 6, TEXT_LIMIT - 2));
        end
        send_pkt();
    endtask

    // main sequence
    initial begin
        int rand_pkts;
        int k;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every keyword, lower, upper and mixed case digits
        for (k = 0; k < KW_COUNT; k++) begin
            hex_case = (k == 0) ? 1 : (k == 1) ? 2 : 0;
            put_prefix();
            put_keyword(k);
            send_pkt();
        end
        hex_case = 0;

        // leading and trailing blanks and tabs
        put_prefix(); put_str(" \t"); put_keyword(2); put_str("\t "); send_pkt();
        // empty text and blanks only
        put_prefix(); send_pkt();
        put_prefix(); put_str(" \t "); send_pkt();
        // inner blank, keyword prefix, keyword with extra letter
        put_prefix(); put_str("con sole"); send_pkt();
        put_prefix(); put_str("hel"); send_pkt();
        put_prefix(); put_str("helps"); send_pkt();
        // short packets
        put_raw_str("qRc"); send_pkt();
        pkt.push_back(8'hff); send_pkt();
        // prefix mismatch
        put_raw_str("qRcmD,"); put_keyword(0); send_pkt();
        // bad hex digit, then bytes that must be ignored
        put_prefix(); put_raw_str("6g"); put_keyword(0); send_pkt();
        put_prefix(); put_raw_str("zz");
        for (int i = 0; i < 10; i++) pkt.push_back(8'($urandom_range(255)));
        send_pkt();
        // odd hex length
        put_prefix(); put_keyword(0); void'(pkt.pop_back()); send_pkt();
        // non-printable characters and the upper printable edge
        put_prefix(); put_char(8'h1f); send_pkt();
        put_prefix(); put_char(8'h7f); send_pkt();
        put_prefix(); put_char(8'hff); send_pkt();
        put_prefix(); put_char(8'h00); send_pkt();
        put_prefix(); put_char(CH_TILDE); send_pkt();
        // text exactly at the limit and one past it
        put_prefix(); put_keyword(0); put_blanks(TEXT_LIMIT - 4); send_pkt();
        put_prefix(); put_keyword(0); put_blanks(TEXT_LIMIT - 3); send_pkt();
        // past the limit, the rest of the packet is ignored
        put_prefix(); put_letters(TEXT_LIMIT + 6); send_pkt();
        // long content, keyword position saturates
        put_prefix(); put_str("statusstatusstatusxx"); send_pkt();
        drain();

        // random packets
        rand_pkts = 0;
        while (bytes_sent < ITEM_TARGET || rand_pkts < RAND_PKTS) begin
            if (rand_pkts == 2) hold_left = 300;
            if (rand_pkts == 5) drain();
            calm = (rand_pkts >= 6 && rand_pkts < 12);
            random_packet();
            rand_pkts++;
        end
        calm = 1'b0;

        // wait for the last verdicts
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/hcpp_pkg.sv
hw/rtl/hcpp_parse.sv
hw/rtl/hcpp_out_reg.sv
hw/rtl/hex_command_packet_parser.sv
hw/rtl/hcpp_checker.sv
dv/hex_command_packet_parser_test.sv
